### src/mpi_pkg.sv
`default_nettype none
package mpi_pkg;

   typedef struct packed {
      logic [11:0] column;
      logic [11:0] row;
   } req_type;

   typedef struct packed {
      logic [7:0] iteration_count;
      logic [2:0] band;
   } rsp_type;

   localparam int FRAC_BITS = 28;
   localparam logic [63:0] ESCAPE_DELTA = 64'd1000 << FRAC_BITS;

   localparam int THRESHOLD_COUNT = 6;
   localparam logic [7:0] BAND_THRESHOLD [THRESHOLD_COUNT] = '{
      8'd0, 8'd8, 8'd20, 8'd50, 8'd100, 8'd200
   };

   localparam logic [2:0] CSR_PAN_X        = 3'd0;
   localparam logic [2:0] CSR_PAN_Y        = 3'd1;
   localparam logic [2:0] CSR_FRAME_WIDTH  = 3'd2;
   localparam logic [2:0] CSR_FRAME_HEIGHT = 3'd3;
   localparam logic [2:0] CSR_VIEW_SCALE   = 3'd4;

   localparam logic signed [63:0] Q_MAX = {1'b0, {63{1'b1}}};
   localparam logic signed [63:0] Q_MIN = {1'b1, {63{1'b0}}};

   function automatic logic [63:0] mag64(input logic signed [63:0] a);
      return a[63] ? (64'd0 - 64'(a)) : 64'(a);
   endfunction

   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
         return s[64] ? Q_MIN : Q_MAX;
      end
      return s[63:0];
   endfunction

   function automatic logic signed [63:0] sat_neg(input logic signed [63:0] a);
      return (a == Q_MIN) ? Q_MAX : -a;
   endfunction

   // Fold an exact unsigned 128-bit product back to signed Q36.28 with saturation.
   function automatic logic signed [63:0] fold_product(input logic [127:0] p,
                                                       input logic neg);
      logic        over;
      logic [63:0] q;
      over = (p[127:92] != '0) || p[91];
      q    = p[91:28];
      if (neg) begin
         return over ? Q_MIN : $signed(64'd0 - q);
      end
      return over ? Q_MAX : $signed(q);
   endfunction

endpackage
`default_nettype wire

### src/mpi_mul64.sv
`default_nettype none
module mpi_mul64 (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [63:0]  a,
   input  wire logic [63:0]  b,
   output logic              done,
   output logic [127:0]      product
);
   logic [63:0]  a_ff, b_ff;
   logic [2:0]   step_ff;
   logic         busy_ff, pp_valid_ff, done_ff;
   logic [63:0]  pp_ff;
   logic [1:0]   shift_ff;
   logic [127:0] acc_ff;
   logic [31:0]  a_half, b_half;
   logic [127:0] acc_in;

   // step bit 1 picks the high half of a, bit 0 the high half of b
   always_comb begin
      a_half = step_ff[1] ? a_ff[63:32] : a_ff[31:0];
      b_half = step_ff[0] ? b_ff[63:32] : b_ff[31:0];
      acc_in = acc_ff + ({64'd0, pp_ff} << {shift_ff, 5'd0});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         done_ff     <= 1'b0;
         pp_valid_ff <= 1'b0;
         step_ff     <= '0;
      end else begin
         done_ff <= !start && busy_ff && step_ff[2];
         if (start) begin
            a_ff        <= a;
            b_ff        <= b;
            step_ff     <= '0;
            busy_ff     <= 1'b1;
            pp_valid_ff <= 1'b0;
            acc_ff      <= '0;
         end else if (busy_ff) begin
            if (pp_valid_ff) begin
               acc_ff <= acc_in;
            end
            if (step_ff[2]) begin
               busy_ff     <= 1'b0;
               pp_valid_ff <= 1'b0;
            end else begin
               pp_ff       <= a_half * b_half;
               shift_ff    <= {1'b0, step_ff[1]} + {1'b0, step_ff[0]};
               pp_valid_ff <= 1'b1;
               step_ff     <= step_ff + 3'd1;
            end
         end
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;
endmodule
`default_nettype wire

### src/mpi_isqrt.sv
`default_nettype none
module mpi_isqrt (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [127:0] radicand,
   output logic              done,
   output logic [63:0]       root
);
   logic [127:0] rad_ff;
   logic [65:0]  rem_ff;
   logic [63:0]  root_ff;
   logic [6:0]   cnt_ff;
   logic         busy_ff, done_ff;
   logic [67:0]  rem_t, trial;
   logic         fits;

   // one result bit per cycle, two radicand bits brought down each step
   always_comb begin
      rem_t = {rem_ff, rad_ff[127:126]};
      trial = {2'b00, root_ff, 2'b01};
      fits  = (rem_t >= trial);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= !start && busy_ff && (cnt_ff == 7'd63);
         if (start) begin
            rad_ff  <= radicand;
            rem_ff  <= '0;
            root_ff <= '0;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rad_ff  <= {rad_ff[125:0], 2'b00};
            rem_ff  <= fits ? 66'(rem_t - trial) : rem_t[65:0];
            root_ff <= {root_ff[62:0], fits};
            cnt_ff  <= cnt_ff + 7'd1;
            if (cnt_ff == 7'd63) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule
`default_nettype wire

### src/mandelbrot_pixel_iteration_core.sv
`default_nettype none
// Escape-time evaluator for one pixel of a Mandelbrot view.
// Request: drive req_pixel (column, row) and pulse start while busy is low; the
// transfer happens at that edge and busy rises for the whole evaluation.
// Result: rsp_valid is high for exactly one cycle with rsp_data (iteration count
// and colour band); the receiver cannot stall, so take it in that cycle.
// Configuration: csr_valid/csr_ready write channel, csr_index picks pan_x, pan_y,
// frame_width, frame_height or view_scale; write only while busy is low.
// csr_ready is always high. Unknown indexes are dropped.
// Sequence: the pixel is mapped first (per axis a 64x64 product on the shared
// 32x32 multiplier and a restoring division by the frame width), then each
// iteration runs five products, two saturating update steps, a bit-serial square
// root of the modulus and the escape check. The next pixel can transfer at the
// same edge at which the result is taken.
// Reset: synchronous, restores register defaults (width/height 500, scale 4.0)
// and drops any pixel in flight.
module mandelbrot_pixel_iteration_core #(
   parameter int ITER_LIMIT = 200,
   parameter int BAND_COUNT = 6
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire mpi_pkg::req_type req_pixel,
   output logic                  rsp_valid,
   output mpi_pkg::rsp_type      rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [2:0]       csr_index,
   input  wire logic [23:0]      csr_data
);
   import mpi_pkg::*;

   localparam int CNT_W = $clog2(ITER_LIMIT + 1);
   localparam int NB    = (BAND_COUNT < THRESHOLD_COUNT) ? BAND_COUNT : THRESHOLD_COUNT;
   localparam int DIV_BITS = 54;

   typedef enum logic [3:0] {
      S_IDLE, S_MUL_START, S_MUL_WAIT, S_DIV, S_CHECK, S_UPD1, S_UPD2, S_SQRT
   } state_type;

   typedef enum logic [2:0] {
      OP_MAP_RE, OP_MAP_IM, OP_ZRR, OP_ZII, OP_ZRI, OP_MOD_R, OP_MOD_I
   } op_type;

   // configuration registers
   logic signed [15:0] pan_x_ff, pan_y_ff;
   logic [12:0]        frame_width_ff, frame_height_ff;
   logic signed [23:0] view_scale_ff;

   state_type          state_ff;
   op_type             op_ff;
   req_type            pixel_ff;
   logic signed [63:0] cr_ff, ci_ff, zr_ff, zi_ff;
   logic signed [63:0] sq_r_ff, sq_i_ff, cross_ff, tr_ff, ti_ff;
   logic [127:0]       mod_r_ff;
   logic [63:0]        mag_ff, prev_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               neg_ff;
   logic [DIV_BITS-1:0] div_q_ff;
   logic [12:0]        div_rem_ff;
   logic [5:0]         div_cnt_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   logic               mul_start, mul_done;
   logic [63:0]        mul_a, mul_b;
   logic [127:0]       mul_product;
   logic               sqrt_start, sqrt_done;
   logic [63:0]        sqrt_root;
   logic [127:0]       sqrt_radicand_ff;

   logic signed [17:0] n_re, n_im, n_sel;
   logic [12:0]        divisor;
   logic [13:0]        div_t;
   logic               div_fit;
   logic [63:0]        diff;
   logic               finish;
   logic [2:0]         band;
   logic signed [63:0] quot_signed;

   // map offsets: pan + position - floor(frame / 2)
   always_comb begin
      n_re = 18'(pan_x_ff) + $signed({6'd0, pixel_ff.column})
             - $signed({6'd0, frame_width_ff[12:1]});
      n_im = 18'(pan_y_ff) + $signed({6'd0, pixel_ff.row})
             - $signed({6'd0, frame_height_ff[12:1]});
      n_sel = (op_ff == OP_MAP_RE) ? n_re : n_im;
      divisor = (frame_width_ff == '0) ? 13'd1 : frame_width_ff;
      div_t   = {div_rem_ff, div_q_ff[DIV_BITS-1]};
      div_fit = (div_t >= {1'b0, divisor});
      diff    = (mag_ff >= prev_ff) ? (mag_ff - prev_ff) : (prev_ff - mag_ff);
      finish  = (diff >= ESCAPE_DELTA) || (count_ff >= CNT_W'(ITER_LIMIT));
      quot_signed = neg_ff ? $signed(64'd0 - 64'(div_q_ff)) : $signed(64'(div_q_ff));
   end

   // operand select for the shared multiplier
   always_comb begin
      case (op_ff)
         OP_MAP_RE, OP_MAP_IM: begin
            mul_a = mag64(64'(n_sel));
            mul_b = mag64(64'(view_scale_ff));
         end
         OP_ZRR, OP_MOD_R: begin
            mul_a = mag64(zr_ff);
            mul_b = mag64(zr_ff);
         end
         OP_ZII, OP_MOD_I: begin
            mul_a = mag64(zi_ff);
            mul_b = mag64(zi_ff);
         end
         OP_ZRI: begin
            mul_a = mag64(zr_ff);
            mul_b = mag64(zi_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      band = '0;
      for (int s = 0; s < NB; s++) begin
         if (16'(count_ff) >= {8'd0, BAND_THRESHOLD[s]}) begin
            band = 3'(s);
         end
      end
   end

   assign mul_start = (state_ff == S_MUL_START);

   mpi_mul64 u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (mul_product)
   );

   mpi_isqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sqrt_radicand_ff),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pan_x_ff        <= '0;
         pan_y_ff        <= '0;
         frame_width_ff  <= 13'd500;
         frame_height_ff <= 13'd500;
         view_scale_ff   <= 24'sd262144;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_PAN_X:        pan_x_ff        <= csr_data[15:0];
            CSR_PAN_Y:        pan_y_ff        <= csr_data[15:0];
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_data[12:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_data[12:0];
            CSR_VIEW_SCALE:   view_scale_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= OP_MAP_RE;
         rsp_valid_ff <= 1'b0;
         sqrt_start   <= 1'b0;
         count_ff     <= '0;
         div_cnt_ff   <= '0;
      end else begin
         // strobe the result on escape or at the iteration limit, kick the root once the modulus sum is ready
         rsp_valid_ff <= (state_ff == S_CHECK) && finish;
         sqrt_start   <= (state_ff == S_MUL_WAIT) && mul_done && (op_ff == OP_MOD_I);
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  pixel_ff <= req_pixel;
                  op_ff    <= OP_MAP_RE;
                  state_ff <= S_MUL_START;
               end
            end
            S_MUL_START: begin
               if (op_ff == OP_MAP_RE || op_ff == OP_MAP_IM) begin
                  neg_ff <= n_sel[17] ^ view_scale_ff[23];
               end
               state_ff <= S_MUL_WAIT;
            end
            S_MUL_WAIT: begin
               if (mul_done) begin
                  case (op_ff)
                     OP_MAP_RE, OP_MAP_IM: begin
                        // scale Q.16 up to Q.28 ahead of the divide
                        div_q_ff   <= {mul_product[41:0], 12'd0};
                        div_rem_ff <= '0;
                        div_cnt_ff <= '0;
                        state_ff   <= S_DIV;
                     end
                     OP_ZRR: begin
                        sq_r_ff  <= fold_product(mul_product, 1'b0);
                        op_ff    <= OP_ZII;
                        state_ff <= S_MUL_START;
                     end
                     OP_ZII: begin
                        sq_i_ff  <= fold_product(mul_product, 1'b0);
                        op_ff    <= OP_ZRI;
                        state_ff <= S_MUL_START;
                     end
                     OP_ZRI: begin
                        cross_ff <= fold_product(mul_product, zr_ff[63] ^ zi_ff[63]);
                        state_ff <= S_UPD1;
                     end
                     OP_MOD_R: begin
                        mod_r_ff <= mul_product;
                        op_ff    <= OP_MOD_I;
                        state_ff <= S_MUL_START;
                     end
                     OP_MOD_I: begin
                        sqrt_radicand_ff <= mod_r_ff + mul_product;
                        state_ff         <= S_SQRT;
                     end
                     default: state_ff <= S_IDLE;
                  endcase
               end
            end
            S_DIV: begin
               if (div_cnt_ff == 6'(DIV_BITS)) begin
                  // quotient complete
                  if (op_ff == OP_MAP_RE) begin
                     cr_ff    <= quot_signed;
                     op_ff    <= OP_MAP_IM;
                     state_ff <= S_MUL_START;
                  end else begin
                     ci_ff    <= quot_signed;
                     zr_ff    <= '0;
                     zi_ff    <= '0;
                     mag_ff   <= '0;
                     prev_ff  <= '0;
                     count_ff <= '0;
                     state_ff <= S_CHECK;
                  end
               end else begin
                  div_rem_ff <= div_fit ? 13'(div_t - {1'b0, divisor}) : div_t[12:0];
                  div_q_ff   <= {div_q_ff[DIV_BITS-2:0], div_fit};
                  div_cnt_ff <= div_cnt_ff + 6'd1;
               end
            end
            S_CHECK: begin
               if (finish) begin
                  rsp_data_ff.iteration_count <= 8'(count_ff);
                  rsp_data_ff.band            <= band;
                  state_ff <= S_IDLE;
               end else begin
                  op_ff    <= OP_ZRR;
                  state_ff <= S_MUL_START;
               end
            end
            S_UPD1: begin
               tr_ff    <= sat_add(sq_r_ff, sat_neg(sq_i_ff));
               ti_ff    <= sat_add(cross_ff, cross_ff);
               state_ff <= S_UPD2;
            end
            S_UPD2: begin
               zr_ff    <= sat_add(tr_ff, cr_ff);
               zi_ff    <= sat_add(ti_ff, ci_ff);
               op_ff    <= OP_MOD_R;
               state_ff <= S_MUL_START;
            end
            S_SQRT: begin
               if (sqrt_done) begin
                  prev_ff  <= mag_ff;
                  mag_ff   <= sqrt_root;
                  count_ff <= count_ff + CNT_W'(1);
                  state_ff <= S_CHECK;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
endmodule
`default_nettype wire
